// File: design/sumo_robot_tactic_fsm_unit_macros.svh
// Assertion macros shared by the sumo tactic design; they sample on clock and skip reset.
`ifndef SUMO_ROBOT_TACTIC_FSM_UNIT_MACROS_SVH
`define SUMO_ROBOT_TACTIC_FSM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRTF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sumo tactic check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRTF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sumo tactic check failed");

`endif

// File: design/srtf_pkg.sv
// Types, codes and constants shared by the sumo tactic design.
`timescale 1ns / 1ps

package srtf_pkg;

   localparam int TIME_BITS = 32;

   typedef logic [TIME_BITS-1:0] time_type;

   localparam time_type OPEN_TARGET = time_type'((64'd1 << (TIME_BITS - 1)) - 64'd1);

   typedef enum logic [2:0] {
      MODE_HUNT   = 3'd0,
      MODE_ESC_R  = 3'd1,
      MODE_ESC_L  = 3'd2,
      MODE_FLAG_L = 3'd3,
      MODE_FLAG_R = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_FWD    = 3'd1,
      KIND_BACK   = 3'd2,
      KIND_SPIN_L = 3'd3,
      KIND_SPIN_R = 3'd4,
      KIND_CUSTOM = 3'd5
   } drive_kind_type;

   typedef enum logic [2:0] {
      CSR_ESCAPE_TIME = 3'd0,
      CSR_ESCAPE_SPIN = 3'd1,
      CSR_FLAG_TIME   = 3'd2,
      CSR_FLAG_SPIN   = 3'd3,
      CSR_CHARGE_THR  = 3'd4
   } csr_index_type;

   localparam logic [3:0] ENEMY_NONE       = 4'd0;
   localparam logic [3:0] ENEMY_LEFT       = 4'd1;
   localparam logic [3:0] ENEMY_RIGHT      = 4'd2;
   localparam logic [3:0] ENEMY_FRONT      = 4'd3;
   localparam logic [3:0] ENEMY_FLAG_LEFT  = 4'd7;
   localparam logic [3:0] ENEMY_FLAG_RIGHT = 4'd8;

   localparam logic [1:0] LINE_OFF  = 2'd0;
   localparam logic [1:0] LINE_LEFT = 2'd1;

   localparam logic [15:0] RESET_ESCAPE_TIME = 16'd220;
   localparam logic [15:0] RESET_ESCAPE_SPIN = 16'd70;
   localparam logic [15:0] RESET_FLAG_TIME   = 16'd150;
   localparam logic [15:0] RESET_FLAG_SPIN   = 16'd50;
   localparam logic signed [15:0] RESET_CHARGE_THR = 16'sd1280;

   localparam logic [7:0] SPEED_ESCAPE   = 8'd180;
   localparam logic [7:0] SPEED_PUNCH    = 8'd255;
   localparam logic [7:0] SPEED_TURN     = 8'd220;
   localparam logic [7:0] SPEED_CHARGE   = 8'd255;
   localparam logic [7:0] SPEED_APPROACH = 8'd100;
   localparam logic [7:0] SEARCH_EVEN_A  = 8'd50;
   localparam logic [7:0] SEARCH_EVEN_B  = 8'd10;
   localparam logic [7:0] SEARCH_ODD_A   = 8'd8;
   localparam logic [7:0] SEARCH_ODD_B   = 8'd50;

   // The search sweep flips every period; the period index comes from a reciprocal multiply.
   localparam int SEARCH_PERIOD_MS = 300;
   localparam int DIV_SHIFT = 40;
   localparam logic [31:0] DIV_RECIP = 32'((64'd1 << DIV_SHIFT) / SEARCH_PERIOD_MS);
   localparam int QUOT_BITS = 64 - DIV_SHIFT;

   typedef struct packed {
      logic [31:0]        time_ms;
      logic signed [15:0] forward_accel;
      logic [3:0]         enemy_position;
      logic [1:0]         line_position;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] drive_kind;
      logic [7:0] speed_a;
      logic [7:0] speed_b;
      logic [2:0] mode_now;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0]        escape_time_ms;
      logic [15:0]        escape_spin_ms;
      logic [15:0]        flag_attack_time_ms;
      logic [15:0]        flag_spin_ms;
      logic signed [15:0] charge_threshold;
   } cfg_type;

   typedef struct packed {
      logic     armed;
      mode_type mode;
      time_type mode_start_ms;
      logic     charge_latched;
   } state_type;

   typedef struct packed {
      drive_kind_type kind;
      logic [7:0]     speed_a;
      logic [7:0]     speed_b;
      mode_type       mode_now;
      logic           custom;
   } decision_type;

endpackage

// File: design/srtf_decide.sv
// Tactic decision for one tick: next state and the motor command without the search sweep.
`timescale 1ns / 1ps

module srtf_decide
   import srtf_pkg::*;
(
   input  state_type       cur_state,
   input  cfg_type         cfg,
   input  req_payload_type item,
   output state_type       nxt_state,
   output decision_type    dec
);

   time_type now;
   time_type elapsed;
   time_type target;
   time_type backup;
   mode_type timed_mode;
   logic     is_esc;
   logic     finished;
   logic     is_flag;
   logic     hunt;

   assign now = time_type'(item.time_ms);
   assign elapsed = now - cur_state.mode_start_ms;
   assign is_esc = (cur_state.mode == MODE_ESC_R) || (cur_state.mode == MODE_ESC_L);
   assign is_flag = (item.enemy_position == ENEMY_FLAG_LEFT) ||
                    (item.enemy_position == ENEMY_FLAG_RIGHT);

   // An unknown mode code is treated as hunting.
   assign timed_mode = (cur_state.mode == MODE_ESC_R) || (cur_state.mode == MODE_ESC_L) ||
                       (cur_state.mode == MODE_FLAG_L) || (cur_state.mode == MODE_FLAG_R)
                       ? cur_state.mode : MODE_HUNT;

   // A zero flag duration leaves the attack open until half the time range.
   always_comb begin
      if (is_esc) begin
         target = time_type'(cfg.escape_time_ms);
      end else if (cfg.flag_attack_time_ms == 16'd0) begin
         target = OPEN_TARGET;
      end else begin
         target = time_type'(cfg.flag_attack_time_ms);
      end
   end

   assign finished = elapsed >= target;
   assign backup = (cfg.escape_time_ms > cfg.escape_spin_ms)
                   ? time_type'(cfg.escape_time_ms - cfg.escape_spin_ms) : '0;

   always_comb begin
      nxt_state = cur_state;
      dec.kind = KIND_NONE;
      dec.speed_a = 8'd0;
      dec.speed_b = 8'd0;
      dec.custom = 1'b0;
      hunt = 1'b0;

      if (!cur_state.armed) begin
         nxt_state.armed = 1'b1;
         nxt_state.mode = MODE_HUNT;
      end else if (item.line_position != LINE_OFF) begin
         nxt_state.mode = (item.line_position == LINE_LEFT) ? MODE_ESC_R : MODE_ESC_L;
         nxt_state.mode_start_ms = now;
      end else begin
         nxt_state.mode = timed_mode;
         if (is_flag && timed_mode == MODE_HUNT) begin
            nxt_state.mode = (item.enemy_position == ENEMY_FLAG_LEFT)
                             ? MODE_FLAG_L : MODE_FLAG_R;
            nxt_state.mode_start_ms = now;
         end else if (timed_mode != MODE_HUNT && !finished) begin
            if ($signed(item.forward_accel) >= $signed(cfg.charge_threshold)) begin
               nxt_state.charge_latched = 1'b1;
            end
            if (is_esc) begin
               dec.speed_a = SPEED_ESCAPE;
               if (elapsed < backup) begin
                  dec.kind = KIND_BACK;
               end else begin
                  dec.kind = (timed_mode == MODE_ESC_R) ? KIND_SPIN_R : KIND_SPIN_L;
               end
            end else begin
               dec.speed_a = SPEED_PUNCH;
               if (elapsed < time_type'(cfg.flag_spin_ms)) begin
                  dec.kind = (timed_mode == MODE_FLAG_L) ? KIND_SPIN_L : KIND_SPIN_R;
               end else begin
                  dec.kind = KIND_FWD;
               end
            end
         end else begin
            nxt_state.mode = MODE_HUNT;
            hunt = 1'b1;
         end
      end

      if (hunt) begin
         case (item.enemy_position)
            ENEMY_NONE: begin
               dec.kind = KIND_CUSTOM;
               dec.custom = 1'b1;
            end
            ENEMY_LEFT: begin
               dec.kind = KIND_SPIN_L;
               dec.speed_a = SPEED_TURN;
            end
            ENEMY_RIGHT: begin
               dec.kind = KIND_SPIN_R;
               dec.speed_a = SPEED_TURN;
            end
            ENEMY_FRONT: begin
               dec.kind = KIND_FWD;
               dec.speed_a = cur_state.charge_latched ? SPEED_CHARGE : SPEED_APPROACH;
            end
            default: begin
               dec.kind = KIND_NONE;
            end
         endcase
      end

      dec.mode_now = nxt_state.mode;
   end

endmodule

// File: design/sumo_robot_tactic_fsm_unit.sv
// Top level of the sumo tactic selector: handshakes, registers, state and search sweep.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_payload_type
//   rsp     | out       | rsp_valid/rsp_stall | rsp_payload_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One tick enters every cycle while req_stall is low; its command passes the input, s2
// and output registers. s2 is there for the sweep period index: a 32 x 32 reciprocal
// multiply after the input register, a remainder correction before the output register.
// Reset clears the stage valids, the tactic state and loads the register defaults.
// rsp_stall holds the output register and backs up through the empty-or-moving stages
// to req_stall in the same cycle; csr_ready is always high.
`timescale 1ns / 1ps
`include "sumo_robot_tactic_fsm_unit_macros.svh"

module sumo_robot_tactic_fsm_unit
   import srtf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_data
);

   cfg_type         cfg_ff, cfg_in;
   state_type       state_ff, state_in;
   state_type       nxt_state;
   decision_type    dec;

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff, s1_data_in;
   logic            s2_valid_ff, s2_valid_in;
   decision_type    s2_dec_ff, s2_dec_in;
   logic [QUOT_BITS-1:0] s2_quot_ff, s2_quot_in;
   logic [31:0]     s2_now_ff, s2_now_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            s3_free, s2_free, s1_free, s1_fire;
   time_type        s1_now;
   logic [31:0]     s1_now32;
   logic [63:0]     s1_prod;
   logic [31:0]     s2_rem;
   logic            sweep_odd;
   logic            rsp_none;
   logic            rsp_custom;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ESCAPE_TIME: cfg_in.escape_time_ms = csr_data;
            CSR_ESCAPE_SPIN: cfg_in.escape_spin_ms = csr_data;
            CSR_FLAG_TIME:   cfg_in.flag_attack_time_ms = csr_data;
            CSR_FLAG_SPIN:   cfg_in.flag_spin_ms = csr_data;
            CSR_CHARGE_THR:  cfg_in.charge_threshold = $signed(csr_data);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign s3_free = !rsp_valid_ff || !rsp_stall;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign s1_fire = s1_valid_ff && s2_free;
   assign req_stall = !s1_free;

   srtf_decide u_decide (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .item      (s1_data_ff),
      .nxt_state (nxt_state),
      .dec       (dec)
   );

   // The estimate from the truncated reciprocal is the true quotient or one below it.
   assign s1_now = time_type'(s1_data_ff.time_ms);
   assign s1_now32 = 32'(s1_now);
   assign s1_prod = 64'(s1_now32) * 64'(DIV_RECIP);

   assign s2_rem = s2_now_ff - 32'(s2_quot_ff) * 32'(SEARCH_PERIOD_MS);
   assign sweep_odd = s2_quot_ff[0] ^ (s2_rem >= 32'(SEARCH_PERIOD_MS));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in = s1_data_ff;
      if (s1_free) begin
         s1_valid_in = req_valid;
         s1_data_in = req_data;
      end

      state_in = s1_fire ? nxt_state : state_ff;

      s2_valid_in = s2_valid_ff;
      s2_dec_in = s2_dec_ff;
      s2_quot_in = s2_quot_ff;
      s2_now_in = s2_now_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
         s2_dec_in = dec;
         s2_quot_in = s1_prod[63:DIV_SHIFT];
         s2_now_in = s1_now32;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (s3_free) begin
         rsp_valid_in = s2_valid_ff;
         rsp_data_in.drive_kind = s2_dec_ff.kind;
         rsp_data_in.mode_now = s2_dec_ff.mode_now;
         rsp_data_in.speed_a = s2_dec_ff.speed_a;
         rsp_data_in.speed_b = s2_dec_ff.speed_b;
         if (s2_dec_ff.custom) begin
            rsp_data_in.speed_a = sweep_odd ? SEARCH_ODD_A : SEARCH_EVEN_A;
            rsp_data_in.speed_b = sweep_odd ? SEARCH_ODD_B : SEARCH_EVEN_B;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_time_ms <= RESET_ESCAPE_TIME;
         cfg_ff.escape_spin_ms <= RESET_ESCAPE_SPIN;
         cfg_ff.flag_attack_time_ms <= RESET_FLAG_TIME;
         cfg_ff.flag_spin_ms <= RESET_FLAG_SPIN;
         cfg_ff.charge_threshold <= RESET_CHARGE_THR;
         state_ff.armed <= 1'b0;
         state_ff.mode <= MODE_HUNT;
         state_ff.mode_start_ms <= '0;
         state_ff.charge_latched <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         state_ff <= state_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_dec_ff <= s2_dec_in;
      s2_quot_ff <= s2_quot_in;
      s2_now_ff <= s2_now_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign rsp_none = rsp_valid && (rsp_data.drive_kind == KIND_NONE);
   assign rsp_custom = rsp_valid && (rsp_data.drive_kind == KIND_CUSTOM);

   `SRTF_ASSERT_IMP(a_none_is_still, rsp_none, {rsp_data.speed_a, rsp_data.speed_b} == 16'd0)
   `SRTF_ASSERT_IMP(a_speed_b_custom_only, rsp_valid && !rsp_custom, rsp_data.speed_b == 8'd0)
   `SRTF_ASSERT_IMP(a_custom_while_hunting, rsp_custom, rsp_data.mode_now == MODE_HUNT)
   `SRTF_ASSERT_NEXT(a_armed_sticks, state_ff.armed, state_ff.armed)
   `SRTF_ASSERT_NEXT(a_charge_sticks, state_ff.charge_latched, state_ff.charge_latched)

endmodule

// File: tb/sumo_robot_tactic_fsm_unit_test.sv
// Self-checking testbench for the sumo tactic selector: random and directed ticks, checked commands.
`timescale 1ns / 1ps

module sumo_robot_tactic_fsm_unit_test;
   import srtf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned REPORT_LIMIT = 40;

   localparam logic [3:0] ENEMY_FAR_FRONT = 4'd4;
   localparam logic [3:0] ENEMY_MID_LEFT  = 4'd5;
   localparam logic [3:0] ENEMY_MID_RIGHT = 4'd6;
   localparam logic [3:0] ENEMY_UNUSED_LO = 4'd9;
   localparam logic [3:0] ENEMY_UNUSED_HI = 4'd15;
   localparam logic [1:0] LINE_RIGHT  = 2'd2;
   localparam logic [1:0] LINE_CENTER = 2'd3;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [2:0]      csr_index = '0;
   logic [15:0]     csr_data = '0;

   sumo_robot_tactic_fsm_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow of the tactic registers and state.
   cfg_type  cfg_shadow = '{RESET_ESCAPE_TIME, RESET_ESCAPE_SPIN, RESET_FLAG_TIME,
                            RESET_FLAG_SPIN, RESET_CHARGE_THR};
   logic     armed = 1'b0;
   mode_type cur_mode = MODE_HUNT;
   time_type mode_start = '0;
   logic     charge_latched = 1'b0;

   req_payload_type pending_ticks[$];
   rsp_payload_type expected_cmds[$];
   time_type        tick_time = '0;
   logic            no_idle = 1'b0;
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     gap_left = 0;
   int unsigned     stall_left = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("sumo_robot_tactic_fsm_unit: mismatch");
      $finish;
   end

   // Works out the motor command of one tick and advances the shadow state.
   function automatic rsp_payload_type predict_command(input req_payload_type tick);
      rsp_payload_type cmd;
      time_type        elapsed;
      time_type        target;
      time_type        period_index;
      logic [15:0]     backup;
      logic            escaping;
      logic            driven;
      cmd = '0;
      driven = 1'b0;
      if (!armed) begin
         armed = 1'b1;
         cur_mode = MODE_HUNT;
         driven = 1'b1;
      end else if (tick.line_position != LINE_OFF) begin
         cur_mode = (tick.line_position == LINE_LEFT) ? MODE_ESC_R : MODE_ESC_L;
         mode_start = tick.time_ms;
         driven = 1'b1;
      end else if ((tick.enemy_position == ENEMY_FLAG_LEFT ||
                    tick.enemy_position == ENEMY_FLAG_RIGHT) && cur_mode == MODE_HUNT) begin
         cur_mode = (tick.enemy_position == ENEMY_FLAG_LEFT) ? MODE_FLAG_L : MODE_FLAG_R;
         mode_start = tick.time_ms;
         driven = 1'b1;
      end else if (cur_mode != MODE_HUNT) begin
         elapsed = tick.time_ms - mode_start;
         escaping = (cur_mode == MODE_ESC_R || cur_mode == MODE_ESC_L);
         if (escaping)
            target = time_type'(cfg_shadow.escape_time_ms);
         else if (cfg_shadow.flag_attack_time_ms == 16'd0)
            target = OPEN_TARGET;
         else
            target = time_type'(cfg_shadow.flag_attack_time_ms);
         if (elapsed >= target) begin
            // The finishing tick falls through to hunting.
            cur_mode = MODE_HUNT;
         end else begin
            driven = 1'b1;
            if ($signed(tick.forward_accel) >= $signed(cfg_shadow.charge_threshold))
               charge_latched = 1'b1;
            if (escaping) begin
               backup = (cfg_shadow.escape_time_ms > cfg_shadow.escape_spin_ms) ?
                        cfg_shadow.escape_time_ms - cfg_shadow.escape_spin_ms : 16'd0;
               cmd.speed_a = SPEED_ESCAPE;
               if (elapsed < time_type'(backup))
                  cmd.drive_kind = KIND_BACK;
               else
                  cmd.drive_kind = (cur_mode == MODE_ESC_R) ? KIND_SPIN_R : KIND_SPIN_L;
            end else begin
               cmd.speed_a = SPEED_PUNCH;
               if (elapsed < time_type'(cfg_shadow.flag_spin_ms))
                  cmd.drive_kind = (cur_mode == MODE_FLAG_L) ? KIND_SPIN_L : KIND_SPIN_R;
               else
                  cmd.drive_kind = KIND_FWD;
            end
         end
      end
      if (!driven) begin
         case (tick.enemy_position)
            ENEMY_NONE: begin
               cmd.drive_kind = KIND_CUSTOM;
               period_index = tick.time_ms / time_type'(SEARCH_PERIOD_MS);
               if (!period_index[0]) begin
                  cmd.speed_a = SEARCH_EVEN_A;
                  cmd.speed_b = SEARCH_EVEN_B;
               end else begin
                  cmd.speed_a = SEARCH_ODD_A;
                  cmd.speed_b = SEARCH_ODD_B;
               end
            end
            ENEMY_LEFT: begin
               cmd.drive_kind = KIND_SPIN_L;
               cmd.speed_a = SPEED_TURN;
            end
            ENEMY_RIGHT: begin
               cmd.drive_kind = KIND_SPIN_R;
               cmd.speed_a = SPEED_TURN;
            end
            ENEMY_FRONT: begin
               cmd.drive_kind = KIND_FWD;
               cmd.speed_a = charge_latched ? SPEED_CHARGE : SPEED_APPROACH;
            end
            default: begin
               cmd.drive_kind = KIND_NONE;
            end
         endcase
      end
      cmd.mode_now = cur_mode;
      return cmd;
   endfunction

   // Mostly small time steps so that timed modes run through all their parts.
   function automatic req_payload_type random_tick();
      req_payload_type tick;
      int unsigned     roll;
      roll = $urandom_range(0, 99);
      if (roll < 75)
         tick_time += $urandom_range(0, 60);
      else if (roll < 95)
         tick_time += $urandom_range(61, 700);
      else
         tick_time = $urandom;
      tick.time_ms = tick_time;
      if ($urandom_range(0, 99) < 30)
         tick.forward_accel = 16'(cfg_shadow.charge_threshold + $urandom_range(0, 4) - 2);
      else
         tick.forward_accel = 16'($urandom);
      if ($urandom_range(0, 99) < 25) begin
         tick.enemy_position = 4'($urandom_range(0, 15));
      end else begin
         case ($urandom_range(0, 5))
            0: tick.enemy_position = ENEMY_NONE;
            1: tick.enemy_position = ENEMY_LEFT;
            2: tick.enemy_position = ENEMY_RIGHT;
            3: tick.enemy_position = ENEMY_FRONT;
            4: tick.enemy_position = ENEMY_FLAG_LEFT;
            default: tick.enemy_position = ENEMY_FLAG_RIGHT;
         endcase
      end
      if ($urandom_range(0, 99) < 88)
         tick.line_position = LINE_OFF;
      else
         tick.line_position = 2'($urandom_range(1, 3));
      return tick;
   endfunction

   task automatic push_tick(input time_type t, input logic [15:0] accel,
                            input logic [3:0] enemy, input logic [1:0] line);
      req_payload_type tick;
      tick.time_ms = t;
      tick.forward_accel = accel;
      tick.enemy_position = enemy;
      tick.line_position = line;
      pending_ticks.push_back(tick);
   endtask

   // Waits until every tick is taken and every command has come back.
   task automatic drain();
      while (pending_ticks.size() != 0 || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) pending_ticks.push_back(random_tick());
      drain();
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_ESCAPE_TIME: cfg_shadow.escape_time_ms = value;
         CSR_ESCAPE_SPIN: cfg_shadow.escape_spin_ms = value;
         CSR_FLAG_TIME:   cfg_shadow.flag_attack_time_ms = value;
         CSR_FLAG_SPIN:   cfg_shadow.flag_spin_ms = value;
         CSR_CHARGE_THR:  cfg_shadow.charge_threshold = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [15:0] esc_time, input logic [15:0] esc_spin,
                           input logic [15:0] flag_time, input logic [15:0] flag_spin,
                           input logic [15:0] threshold);
      write_reg(CSR_ESCAPE_TIME, esc_time);
      write_reg(CSR_ESCAPE_SPIN, esc_spin);
      write_reg(CSR_FLAG_TIME, flag_time);
      write_reg(CSR_FLAG_SPIN, flag_spin);
      write_reg(CSR_CHARGE_THR, threshold);
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // Tick driver: a beat stays on the bus until taken, then a random gap may follow.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_cmds.push_back(predict_command(req_data));
            void'(pending_ticks.pop_front());
            if (!no_idle && $urandom_range(0, 99) < 12)
               gap_left = $urandom_range(1, 14);
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_ticks.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_ticks[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Command monitor with random stall bursts.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: no command expected, got %h", $time, rsp_data);
            end else begin
               want = expected_cmds.pop_front();
               check_field("drive_kind", want.drive_kind, rsp_data.drive_kind);
               check_field("speed_a", want.speed_a, rsp_data.speed_a);
               check_field("speed_b", want.speed_b, rsp_data.speed_b);
               check_field("mode_now", want.mode_now, rsp_data.mode_now);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!no_idle && $urandom_range(0, 99) < 10) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 14) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: arming, every hunting code, both timed modes and wrap-around.
      push_tick(32'd0, 16'h7FFF, ENEMY_FRONT, LINE_CENTER);
      push_tick(32'd100, 16'd0, ENEMY_NONE, LINE_OFF);
      push_tick(32'd300, 16'd0, ENEMY_NONE, LINE_OFF);
      push_tick(32'd310, 16'd0, ENEMY_LEFT, LINE_OFF);
      push_tick(32'd320, 16'd0, ENEMY_RIGHT, LINE_OFF);
      push_tick(32'd330, 16'h8000, ENEMY_FRONT, LINE_OFF);
      push_tick(32'd340, 16'd0, ENEMY_FAR_FRONT, LINE_OFF);
      push_tick(32'd350, 16'd0, ENEMY_MID_LEFT, LINE_OFF);
      push_tick(32'd360, 16'd0, ENEMY_MID_RIGHT, LINE_OFF);
      push_tick(32'd370, 16'd0, ENEMY_UNUSED_LO, LINE_OFF);
      push_tick(32'd380, 16'd0, ENEMY_UNUSED_HI, LINE_OFF);
      push_tick(32'd1000, 16'd0, ENEMY_FLAG_LEFT, LINE_OFF);
      push_tick(32'd1010, 16'd1279, ENEMY_FLAG_RIGHT, LINE_OFF);
      push_tick(32'd1060, 16'd0, ENEMY_NONE, LINE_OFF);
      push_tick(32'd1150, 16'd0, ENEMY_FRONT, LINE_OFF);
      push_tick(32'd1200, 16'd0, ENEMY_NONE, LINE_LEFT);
      push_tick(32'd1300, 16'd1280, ENEMY_NONE, LINE_OFF);
      push_tick(32'd1360, 16'd0, ENEMY_NONE, LINE_OFF);
      push_tick(32'd1420, 16'd0, ENEMY_FRONT, LINE_OFF);
      push_tick(32'd1500, 16'd0, ENEMY_NONE, LINE_CENTER);
      push_tick(32'd1510, 16'd0, ENEMY_NONE, LINE_RIGHT);
      push_tick(32'd1700, 16'd0, ENEMY_NONE, LINE_OFF);
      push_tick(32'd1800, 16'd0, ENEMY_FLAG_RIGHT, LINE_OFF);
      push_tick(32'd1810, 16'd0, ENEMY_FLAG_RIGHT, LINE_OFF);
      push_tick(32'd1820, 16'd0, ENEMY_NONE, LINE_OFF);
      push_tick(32'hFFFF_FFF0, 16'd0, ENEMY_NONE, LINE_LEFT);
      push_tick(32'h0000_0010, 16'd0, ENEMY_NONE, LINE_OFF);
      drain();

      // Open-ended flag attack and an escape that only spins.
      set_regs(16'd50, 16'd60, 16'd0, 16'hFFFF, 16'h7FFF);
      push_tick(32'h0000_1000, 16'd0, ENEMY_NONE, LINE_OFF);
      push_tick(32'h0000_2000, 16'd0, ENEMY_FLAG_LEFT, LINE_OFF);
      push_tick(32'h8000_1FFE, 16'h7FFF, ENEMY_NONE, LINE_OFF);
      push_tick(32'h8000_1FFF, 16'd0, ENEMY_FRONT, LINE_OFF);
      push_tick(32'd100, 16'd0, ENEMY_NONE, LINE_LEFT);
      push_tick(32'd110, 16'd0, ENEMY_NONE, LINE_OFF);
      run_random(180);

      // A zero-length escape ends on the very next tick; this stretch runs without idling.
      set_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'h8000);
      no_idle = 1'b1;
      push_tick(32'd500, 16'd0, ENEMY_NONE, LINE_RIGHT);
      push_tick(32'd500, 16'd0, ENEMY_RIGHT, LINE_OFF);
      run_random(180);
      no_idle = 1'b0;

      set_regs(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd0);
      run_random(180);

      repeat (4) begin
         set_regs(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                  16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                  16'($urandom));
         run_random(100);
         run_random(100);
      end

      set_regs(RESET_ESCAPE_TIME, RESET_ESCAPE_SPIN, RESET_FLAG_TIME, RESET_FLAG_SPIN,
               RESET_CHARGE_THR);
      no_idle = 1'b1;
      run_random(150);

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_cmds.size() == 0)
         $display("sumo_robot_tactic_fsm_unit: match");
      else
         $display("sumo_robot_tactic_fsm_unit: mismatch");
      $finish;
   end

endmodule

// File: sumo_robot_tactic_fsm_unit.f
+incdir+design
design/srtf_pkg.sv
design/srtf_decide.sv
design/sumo_robot_tactic_fsm_unit.sv
tb/sumo_robot_tactic_fsm_unit_test.sv
